### rtl/bvm_pkg.sv
// ----------------------------------------------------------------------------
// bvm_pkg - shared types and constants of the battery voltage monitor
// Widths, register codes, reset values, level and status codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package bvm_pkg;

  // converter and field widths
  localparam int ADC_BITS    = 12;
  localparam int GAIN_W      = 24;
  localparam int MV_W        = 16;
  localparam int PCT_W       = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int FRAC_BITS   = 16;

  // default block length
  localparam int SAMPLES_DEF = 16;

  // percent scale and rounding constant
  localparam int PCT_FULL    = 100;
  localparam int RND_HALF    = 1 << (FRAC_BITS - 1);

  // shared divider: dividend holds (mv excess) * 100, divisor a mv span
  localparam int DIV_W       = MV_W + PCT_W;
  localparam int DEN_W       = MV_W;
  localparam int DCNT_W      = $clog2(DIV_W);

  // register reset values
  localparam logic [MV_W-1:0] EMPTY_MV_RST = 16'd6000;
  localparam logic [MV_W-1:0] FULL_MV_RST  = 16'd8400;
  localparam logic [MV_W-1:0] PRES_MV_RST  = 16'd3000;
  localparam logic [MV_W-1:0] OVER_MV_RST  = 16'd8600;
  localparam logic [MV_W-1:0] CRIT_MV_RST  = 16'd6400;
  localparam logic [MV_W-1:0] LOW_MV_RST   = 16'd7000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CALIBRATED = 3'd0,
    CFG_GAIN       = 3'd1,
    CFG_EMPTY_MV   = 3'd2,
    CFG_FULL_MV    = 3'd3,
    CFG_PRESENT_MV = 3'd4,
    CFG_OVER_MV    = 3'd5,
    CFG_CRIT_MV    = 3'd6,
    CFG_LOW_MV     = 3'd7
  } cfg_idx_e;

  // battery level codes
  typedef enum logic [2:0] {
    LVL_UNAVAIL  = 3'd0,
    LVL_CRITICAL = 3'd1,
    LVL_LOW      = 3'd2,
    LVL_NORMAL   = 3'd3,
    LVL_OVER     = 3'd4
  } level_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_INIT = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_OVERVOLT = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_MEAN  = 3'd1,
    S_MUL   = 3'd2,
    S_SCALE = 3'd3,
    S_RANGE = 3'd4,
    S_PCT   = 3'd5,
    S_DONE  = 3'd6
  } seq_state_e;

endpackage

### rtl/battery_voltage_monitor_top.sv
// ----------------------------------------------------------------------------
// battery_voltage_monitor_top - battery voltage level monitor
// Averages blocks of ADC samples, scales the mean to millivolts, derives a
// charge percent and a level state, and emits one result per block, per
// conversion failure and per sample taken while not calibrated.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+-----------
//  input    | in_valid_i, in_stall_o, adc_sample_i,    | in
//           | conversion_failed_i                      |
//  output   | out_valid_o, out_stall_i, raw_average_o, | out
//           | batt_mv_o, percent_o, level_state_o,     |
//           | status_o                                 |
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i          | in
//
// Failures and uncalibrated samples get a registered result from the idle
// state; other samples that do not end a block are summed. A block end
// takes the mean by reciprocal multiply, then the gain multiply, scale and
// range steps, the shared restoring divider over the DIV_W = 23 bit percent
// dividend and the finish step, skipping the divider unless the voltage is
// strictly between the empty and full limits. Reset is asynchronous, active
// low, and clears the control state, accumulator and held values. The input
// stalls while the sequencer is busy or a result waits unaccepted.
// ----------------------------------------------------------------------------
module battery_voltage_monitor_top
  import bvm_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input transaction
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ADC_BITS-1:0]   adc_sample_i,
  input  logic                  conversion_failed_i,
  // output transaction
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ADC_BITS-1:0]   raw_average_o,
  output logic [MV_W-1:0]       batt_mv_o,
  output logic [PCT_W-1:0]      percent_o,
  output logic [2:0]            level_state_o,
  output logic [1:0]            status_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SUM_W  = ADC_BITS + $clog2(SAMPLES);
  localparam int CNT_W  = $clog2(SAMPLES + 1);
  localparam int PROD_W = ADC_BITS + GAIN_W;
  localparam int RMV_W  = PROD_W + 1 - FRAC_BITS;

  // mean by reciprocal multiply, exact for every block sum
  localparam int MEAN_SH = SUM_W + $clog2(SAMPLES);
  localparam int RCP_W   = SUM_W + 2;
  localparam int MPROD_W = SUM_W + RCP_W;
  localparam longint unsigned MEAN_RCP =
    ((64'd1 << MEAN_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);

  // configuration registers
  logic              calib_q;
  logic [GAIN_W-1:0] gain_q;
  logic [MV_W-1:0]   empty_mv_q, full_mv_q, pres_mv_q, over_mv_q, crit_mv_q, low_mv_q;

  // sequencer and accumulator
  seq_state_e        state_q, state_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // shared divider
  logic [DEN_W-1:0]  div_rem_q, div_rem_d;
  logic [DIV_W-1:0]  div_quo_q, div_quo_d;
  logic [DEN_W-1:0]  div_den_q, div_den_d;
  logic [DCNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [DEN_W:0]    div_rem_sh, div_sub;
  logic              div_ge, div_last;
  logic [DEN_W-1:0]  div_rem_nx;
  logic [DIV_W-1:0]  div_quo_nx;

  // datapath
  logic [ADC_BITS-1:0] mean_q, mean_d;
  logic [MPROD_W-1:0]  mean_prod;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [MV_W-1:0]     held_mv_q, held_mv_d;
  logic [PCT_W-1:0]    held_pct_q, held_pct_d;
  logic [PROD_W:0]     rnd_sum;
  logic [RMV_W-1:0]    rnd_mv;
  logic [MV_W-1:0]     excess_mv, span_mv;
  logic [DIV_W-1:0]    pct_num;
  level_e              level;
  logic [SUM_W-1:0]    sum_total;
  logic                in_acc, cnt_last, out_free;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [ADC_BITS-1:0] out_raw_q, out_raw_d;
  logic [MV_W-1:0]     out_mv_q, out_mv_d;
  logic [PCT_W-1:0]    out_pct_q, out_pct_d;
  level_e              out_lvl_q, out_lvl_d;
  status_e             out_st_q, out_st_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cnt_last   = (cnt_q == CNT_W'(SAMPLES - 1));
  assign sum_total  = sum_q + SUM_W'(adc_sample_i);

  // block mean from the held block sum
  assign mean_prod = MPROD_W'(sum_q) * MPROD_W'(MEAN_RCP);

  // divider step: one quotient bit per cycle
  assign div_rem_sh = {div_rem_q, div_quo_q[DIV_W-1]};
  assign div_sub    = div_rem_sh - {1'b0, div_den_q};
  assign div_ge     = (div_rem_sh >= {1'b0, div_den_q});
  assign div_rem_nx = div_ge ? div_sub[DEN_W-1:0] : div_rem_sh[DEN_W-1:0];
  assign div_quo_nx = {div_quo_q[DIV_W-2:0], div_ge};
  assign div_last   = (div_cnt_q == DCNT_W'(DIV_W - 1));

  // rounding and saturation of the scaled product
  assign rnd_sum = {1'b0, prod_q} + (PROD_W + 1)'(RND_HALF);
  assign rnd_mv  = rnd_sum[PROD_W:FRAC_BITS];

  // percent operands
  assign excess_mv = held_mv_q - empty_mv_q;
  assign span_mv   = full_mv_q - empty_mv_q;
  assign pct_num   = DIV_W'(excess_mv) * DIV_W'(PCT_FULL);

  // level classification, first match wins
  always_comb begin
    if (held_mv_q < pres_mv_q) begin
      level = LVL_UNAVAIL;
    end else if (held_mv_q > over_mv_q) begin
      level = LVL_OVER;
    end else if (held_mv_q <= crit_mv_q) begin
      level = LVL_CRITICAL;
    end else if (held_mv_q <= low_mv_q) begin
      level = LVL_LOW;
    end else begin
      level = LVL_NORMAL;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && calib_q && !conversion_failed_i && cnt_last) begin
          state_d = S_MEAN;
        end
      end
      S_MEAN:  state_d = S_MUL;
      S_MUL:   state_d = S_SCALE;
      S_SCALE: state_d = S_RANGE;
      S_RANGE: begin
        if (held_mv_q <= empty_mv_q || held_mv_q >= full_mv_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_PCT;
        end
      end
      S_PCT: begin
        if (div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and output register updates
  always_comb begin
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    div_rem_d   = div_rem_q;
    div_quo_d   = div_quo_q;
    div_den_d   = div_den_q;
    div_cnt_d   = div_cnt_q;
    mean_d      = mean_q;
    prod_d      = prod_q;
    held_mv_d   = held_mv_q;
    held_pct_d  = held_pct_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_raw_d   = out_raw_q;
    out_mv_d    = out_mv_q;
    out_pct_d   = out_pct_q;
    out_lvl_d   = out_lvl_q;
    out_st_d    = out_st_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!calib_q) begin
            out_valid_d = 1'b1;
            out_raw_d   = '0;
            out_mv_d    = held_mv_q;
            out_pct_d   = held_pct_q;
            out_lvl_d   = LVL_UNAVAIL;
            out_st_d    = ST_NOT_INIT;
          end else if (conversion_failed_i) begin
            sum_d       = '0;
            cnt_d       = '0;
            out_valid_d = 1'b1;
            out_raw_d   = '0;
            out_mv_d    = held_mv_q;
            out_pct_d   = held_pct_q;
            out_lvl_d   = LVL_UNAVAIL;
            out_st_d    = ST_TIMEOUT;
          end else if (cnt_last) begin
            // block end: keep the block sum for the mean step
            sum_d = sum_total;
            cnt_d = '0;
          end else begin
            sum_d = sum_total;
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      S_MEAN: begin
        mean_d = mean_prod[MEAN_SH +: ADC_BITS];
        sum_d  = '0;
      end
      S_MUL: begin
        prod_d = PROD_W'(mean_q) * PROD_W'(gain_q);
      end
      S_SCALE: begin
        held_mv_d = (rnd_mv[RMV_W-1:MV_W] != '0) ? '1 : rnd_mv[MV_W-1:0];
      end
      S_RANGE: begin
        if (held_mv_q <= empty_mv_q) begin
          held_pct_d = '0;
        end else if (held_mv_q >= full_mv_q) begin
          held_pct_d = PCT_W'(PCT_FULL);
        end else begin
          div_rem_d = '0;
          div_quo_d = pct_num;
          div_den_d = span_mv;
          div_cnt_d = '0;
        end
      end
      S_PCT: begin
        div_rem_d = div_rem_nx;
        div_quo_d = div_quo_nx;
        div_cnt_d = div_cnt_q + DCNT_W'(1);
        if (div_last) begin
          held_pct_d = div_quo_nx[PCT_W-1:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_raw_d   = mean_q;
          out_mv_d    = held_mv_q;
          out_pct_d   = held_pct_q;
          out_lvl_d   = level;
          out_st_d    = (level == LVL_OVER) ? ST_OVERVOLT : ST_OK;
        end
      end
      default: ;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      held_mv_q   <= '0;
      held_pct_q  <= '0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      held_mv_q   <= held_mv_d;
      held_pct_q  <= held_pct_d;
      out_valid_q <= out_valid_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
    div_den_q <= div_den_d;
    mean_q    <= mean_d;
    prod_q    <= prod_d;
    out_raw_q <= out_raw_d;
    out_mv_q  <= out_mv_d;
    out_pct_q <= out_pct_d;
    out_lvl_q <= out_lvl_d;
    out_st_q  <= out_st_d;
  end

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q    <= 1'b0;
      gain_q     <= '0;
      empty_mv_q <= EMPTY_MV_RST;
      full_mv_q  <= FULL_MV_RST;
      pres_mv_q  <= PRES_MV_RST;
      over_mv_q  <= OVER_MV_RST;
      crit_mv_q  <= CRIT_MV_RST;
      low_mv_q   <= LOW_MV_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CALIBRATED: calib_q    <= cfg_data_i[0];
        CFG_GAIN:       gain_q     <= cfg_data_i[GAIN_W-1:0];
        CFG_EMPTY_MV:   empty_mv_q <= cfg_data_i[MV_W-1:0];
        CFG_FULL_MV:    full_mv_q  <= cfg_data_i[MV_W-1:0];
        CFG_PRESENT_MV: pres_mv_q  <= cfg_data_i[MV_W-1:0];
        CFG_OVER_MV:    over_mv_q  <= cfg_data_i[MV_W-1:0];
        CFG_CRIT_MV:    crit_mv_q  <= cfg_data_i[MV_W-1:0];
        CFG_LOW_MV:     low_mv_q   <= cfg_data_i[MV_W-1:0];
        default: ;
      endcase
    end
  end

  // output ports
  assign out_valid_o   = out_valid_q;
  assign raw_average_o = out_raw_q;
  assign batt_mv_o     = out_mv_q;
  assign percent_o     = out_pct_q;
  assign level_state_o = out_lvl_q;
  assign status_o      = out_st_q;

endmodule
